### src/kronecker_matrix_vector_product_top_assert.svh
// ---------------------------------------------------------------------------
// kronecker matrix-vector product assertion macros
// shared concurrent assertion forms for the controller
// ---------------------------------------------------------------------------
`ifndef KRONECKER_MATRIX_VECTOR_PRODUCT_TOP_ASSERT_SVH
`define KRONECKER_MATRIX_VECTOR_PRODUCT_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define KMVP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("kmvp assertion failed");

// antecedent implies consequent in the next cycle
`define KMVP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("kmvp assertion failed");

`endif

### src/kmvp_pkg.sv
// ---------------------------------------------------------------------------
// kmvp_pkg
// types and constants shared by the kronecker matrix-vector product block
// ---------------------------------------------------------------------------
package kmvp_pkg;

  localparam int NUM_FACTORS  = 4;
  localparam int MAX_DIM      = 8;
  localparam int MAX_VEC      = 4096;
  localparam int VEC_AW       = 12;
  localparam int LEN_W        = VEC_AW + 1;
  localparam int DIM_W        = 3;
  localparam int SEL_W        = 2;
  localparam int SIZE_W       = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int DATA_W       = 32;
  localparam int FS_AW        = SEL_W + 2 * DIM_W;
  localparam int FSTORE_DEPTH = NUM_FACTORS * MAX_DIM * MAX_DIM;
  localparam int ACC_W        = 68;
  localparam int CNT_W        = 3;

  typedef enum logic [1:0] {
    K_LOAD_MAT = 2'd0,
    K_LOAD_VEC = 2'd1,
    K_START    = 2'd2,
    K_READ     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SIZE  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic             accept;
    logic             rd_resp;
    logic             report;
    status_t          rep_status;
    logic             set_res;
    logic             res_b;
    logic             span_clr;
    logic             span_mul;
    logic             left_clr;
    logic             left_mul;
    logic             right_clr;
    logic             right_mul;
    logic [SEL_W-1:0] idx;
    logic [SEL_W-1:0] p;
    logic             sweep_init;
    logic             run;
    logic             src_b;
  } cmd_t;

  typedef struct packed {
    logic             shape_ok;
    logic [CNT_W-1:0] count;
    logic             span_over;
    logic             sweep_last;
    logic             pipe_empty;
  } stat_t;

endpackage

### src/kmvp_ram.sv
// ---------------------------------------------------------------------------
// kmvp_ram
// simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module kmvp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/kmvp_datapath.sv
// ---------------------------------------------------------------------------
// kmvp_datapath
// size registers, sweep address generation, mac pipeline, memories, outputs
// ---------------------------------------------------------------------------
module kmvp_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  kmvp_pkg::cmd_t                     cmd,
  output kmvp_pkg::stat_t                    st,
  input  logic                               cfg_we,
  input  logic [kmvp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kmvp_pkg::SIZE_W-1:0]        cfg_data,
  input  logic [1:0]                         in_kind,
  input  logic [kmvp_pkg::SEL_W-1:0]         in_factor_sel,
  input  logic [kmvp_pkg::DIM_W-1:0]         in_row_idx,
  input  logic [kmvp_pkg::DIM_W-1:0]         in_col_idx,
  input  logic [kmvp_pkg::VEC_AW-1:0]        in_vec_idx,
  input  logic signed [kmvp_pkg::DATA_W-1:0] in_data_in,
  output logic                               out_valid,
  output logic signed [kmvp_pkg::DATA_W-1:0] out_data_out,
  output logic [1:0]                         out_status
);
  import kmvp_pkg::*;

  logic [SIZE_W-1:0] rows_r [NUM_FACTORS];
  logic [SIZE_W-1:0] cols_r [NUM_FACTORS];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_FACTORS; k++) begin
        rows_r[k] <= (k == 0) ? SIZE_W'(1) : '0;
        cols_r[k] <= (k == 0) ? SIZE_W'(1) : '0;
      end
    end else if (cfg_we) begin
      if (cfg_index[0]) begin
        cols_r[cfg_index[CFG_IDX_W-1:1]] <= cfg_data;
      end else begin
        rows_r[cfg_index[CFG_IDX_W-1:1]] <= cfg_data;
      end
    end
  end

  // shape check
  logic             shape_ok;
  logic             absent_seen;
  logic [CNT_W-1:0] count;

  always_comb begin
    shape_ok    = 1'b1;
    absent_seen = 1'b0;
    count       = '0;
    for (int k = 0; k < NUM_FACTORS; k++) begin
      if (rows_r[k] == '0) begin
        if (k == 0) begin
          shape_ok = 1'b0;
        end
        absent_seen = 1'b1;
      end else begin
        if (absent_seen) begin
          shape_ok = 1'b0;
        end
        if (cols_r[k] == '0 || rows_r[k] > SIZE_W'(MAX_DIM) ||
            cols_r[k] > SIZE_W'(MAX_DIM)) begin
          shape_ok = 1'b0;
        end
        count = CNT_W'(k + 1);
      end
    end
  end

  // span, left and right products
  logic [15:0]       span_r;
  logic              span_over_r;
  logic [SIZE_W-1:0] span_mx;
  logic [19:0]       span_prod;
  logic [LEN_W-1:0]  left_r;
  logic [LEN_W-1:0]  right_r;
  logic [16:0]       left_prod;
  logic [16:0]       right_prod;

  assign span_mx    = (rows_r[cmd.idx] > cols_r[cmd.idx]) ? rows_r[cmd.idx] : cols_r[cmd.idx];
  assign span_prod  = 20'(span_r) * 20'(span_mx);
  assign left_prod  = 17'(left_r) * 17'(cols_r[cmd.idx]);
  assign right_prod = 17'(right_r) * 17'(rows_r[cmd.idx]);

  always_ff @(posedge clk) begin
    if (cmd.span_clr) begin
      span_r      <= 16'd1;
      span_over_r <= 1'b0;
    end else if (cmd.span_mul) begin
      span_r <= span_prod[15:0];
      if (span_prod > 20'(MAX_VEC)) begin
        span_over_r <= 1'b1;
      end
    end
    if (cmd.left_clr) begin
      left_r <= LEN_W'(1);
    end else if (cmd.left_mul) begin
      left_r <= left_prod[LEN_W-1:0];
    end
    if (cmd.right_clr) begin
      right_r <= LEN_W'(1);
    end else if (cmd.right_mul) begin
      right_r <= right_prod[LEN_W-1:0];
    end
  end

  // sweep counters and addresses
  logic [VEC_AW-1:0] s_r, j_r;
  logic [DIM_W-1:0]  r_r, c_r;
  logic [SIZE_W-1:0] nr_r, nc_r;
  logic [VEC_AW-1:0] rnc_r, rnr_r;
  logic [VEC_AW-1:0] in_base_r, in_j_r, in_addr_r;
  logic [VEC_AW-1:0] out_base_r, out_j_r, out_addr_r;
  logic [VEC_AW-1:0] in_base_nxt, out_base_nxt, in_j_nxt, out_j_nxt;
  logic [VEC_AW-1:0] right_lo;
  logic [16:0]       rnc_prod, rnr_prod;
  logic              last_c, last_r, last_j, last_s;

  assign right_lo     = right_r[VEC_AW-1:0];
  assign rnc_prod     = 17'(right_r) * 17'(cols_r[cmd.p]);
  assign rnr_prod     = 17'(right_r) * 17'(rows_r[cmd.p]);
  assign last_c       = {1'b0, c_r} == (nc_r - SIZE_W'(1));
  assign last_r       = {1'b0, r_r} == (nr_r - SIZE_W'(1));
  assign last_j       = {1'b0, j_r} == (right_r - LEN_W'(1));
  assign last_s       = {1'b0, s_r} == (left_r - LEN_W'(1));
  assign in_base_nxt  = in_base_r + rnc_r;
  assign out_base_nxt = out_base_r + rnr_r;
  assign in_j_nxt     = in_j_r + VEC_AW'(1);
  assign out_j_nxt    = out_j_r + VEC_AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.sweep_init) begin
      s_r        <= '0;
      j_r        <= '0;
      r_r        <= '0;
      c_r        <= '0;
      nr_r       <= rows_r[cmd.p];
      nc_r       <= cols_r[cmd.p];
      rnc_r      <= rnc_prod[VEC_AW-1:0];
      rnr_r      <= rnr_prod[VEC_AW-1:0];
      in_base_r  <= '0;
      in_j_r     <= '0;
      in_addr_r  <= '0;
      out_base_r <= '0;
      out_j_r    <= '0;
      out_addr_r <= '0;
    end else if (cmd.run) begin
      if (!last_c) begin
        c_r       <= c_r + DIM_W'(1);
        in_addr_r <= in_addr_r + right_lo;
      end else begin
        c_r <= '0;
        if (!last_r) begin
          r_r        <= r_r + DIM_W'(1);
          in_addr_r  <= in_j_r;
          out_addr_r <= out_addr_r + right_lo;
        end else begin
          r_r <= '0;
          if (!last_j) begin
            j_r        <= j_r + VEC_AW'(1);
            in_j_r     <= in_j_nxt;
            in_addr_r  <= in_j_nxt;
            out_j_r    <= out_j_nxt;
            out_addr_r <= out_j_nxt;
          end else begin
            j_r        <= '0;
            s_r        <= s_r + VEC_AW'(1);
            in_base_r  <= in_base_nxt;
            in_j_r     <= in_base_nxt;
            in_addr_r  <= in_base_nxt;
            out_base_r <= out_base_nxt;
            out_j_r    <= out_base_nxt;
            out_addr_r <= out_base_nxt;
          end
        end
      end
    end
  end

  // memories
  logic              load_mat, load_vec, mat_bad, vec_bad;
  logic              fs_we, a_we, b_we;
  logic [FS_AW-1:0]  fs_raddr;
  logic [VEC_AW-1:0] a_waddr, a_raddr, b_raddr;
  logic [DATA_W-1:0] a_wdata, fs_q, a_q, b_q;
  logic              wr_v_r;
  logic [VEC_AW-1:0] wr_addr_r;
  logic [DATA_W-1:0] wr_data_r;

  assign mat_bad  = ({1'b0, in_factor_sel} >= 3'(NUM_FACTORS)) ||
                    ({1'b0, in_row_idx} >= 4'(MAX_DIM)) ||
                    ({1'b0, in_col_idx} >= 4'(MAX_DIM));
  assign vec_bad  = {1'b0, in_vec_idx} >= LEN_W'(MAX_VEC);
  assign load_mat = cmd.accept && (kind_t'(in_kind) == K_LOAD_MAT);
  assign load_vec = cmd.accept && (kind_t'(in_kind) == K_LOAD_VEC);
  assign fs_we    = load_mat && !mat_bad;
  assign fs_raddr = {cmd.p, r_r, c_r};
  assign a_we     = (load_vec && !vec_bad) || (wr_v_r && cmd.src_b);
  assign a_waddr  = wr_v_r ? wr_addr_r : in_vec_idx;
  assign a_wdata  = wr_v_r ? wr_data_r : in_data_in;
  assign b_we     = wr_v_r && !cmd.src_b;
  assign a_raddr  = cmd.accept ? in_vec_idx : in_addr_r;
  assign b_raddr  = cmd.accept ? in_vec_idx : in_addr_r;

  kmvp_ram #(.WIDTH(DATA_W), .DEPTH(FSTORE_DEPTH)) u_fstore (
    .clk   (clk),
    .we    (fs_we),
    .waddr ({in_factor_sel, in_row_idx, in_col_idx}),
    .wdata (in_data_in),
    .raddr (fs_raddr),
    .rdata (fs_q)
  );

  kmvp_ram #(.WIDTH(DATA_W), .DEPTH(MAX_VEC)) u_buf_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_q)
  );

  kmvp_ram #(.WIDTH(DATA_W), .DEPTH(MAX_VEC)) u_buf_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (wr_addr_r),
    .wdata (wr_data_r),
    .raddr (b_raddr),
    .rdata (b_q)
  );

  // mac pipeline
  logic                    v1_r, first1_r, last1_r;
  logic [VEC_AW-1:0]       oaddr1_r;
  logic                    v2_r, first2_r, last2_r;
  logic [VEC_AW-1:0]       oaddr2_r;
  logic signed [63:0]      prod_r, prod_nxt;
  logic                    v3_r, last3_r;
  logic [VEC_AW-1:0]       oaddr3_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, prod_ext, rnd;
  logic [DATA_W-1:0]       src_q, sat_val;
  logic [ACC_W-17:0]       shifted;

  assign src_q    = cmd.src_b ? b_q : a_q;
  assign prod_nxt = $signed(fs_q) * $signed(src_q);
  assign prod_ext = {{(ACC_W-64){prod_r[63]}}, prod_r};
  assign acc_nxt  = first2_r ? prod_ext : acc_r + prod_ext;
  assign rnd      = acc_r + ACC_W'(32768);
  assign shifted  = rnd[ACC_W-1:16];

  // round half up, then saturate
  always_comb begin
    if (&shifted[ACC_W-17:DATA_W-1] || ~|shifted[ACC_W-17:DATA_W-1]) begin
      sat_val = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-17]) begin
      sat_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      wr_v_r <= 1'b0;
    end else begin
      v1_r   <= cmd.run;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      wr_v_r <= v3_r && last3_r;
    end
    first1_r  <= (c_r == '0);
    last1_r   <= last_c;
    oaddr1_r  <= out_addr_r;
    first2_r  <= first1_r;
    last2_r   <= last1_r;
    oaddr2_r  <= oaddr1_r;
    prod_r    <= prod_nxt;
    last3_r   <= last2_r;
    oaddr3_r  <= oaddr2_r;
    if (v2_r) begin
      acc_r <= acc_nxt;
    end
    wr_addr_r <= oaddr3_r;
    wr_data_r <= sat_val;
  end

  // result register and outputs
  logic              res_b_r;
  logic              rd_bad_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  status_t           out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_b_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.set_res) begin
        res_b_r <= cmd.res_b;
      end
      out_valid_r <= cmd.rd_resp || cmd.report || load_mat || load_vec;
    end
    if (cmd.accept) begin
      rd_bad_r <= vec_bad;
    end
    if (cmd.rd_resp) begin
      out_data_r   <= rd_bad_r ? '0 : (res_b_r ? b_q : a_q);
      out_status_r <= rd_bad_r ? ST_RANGE : ST_OK;
    end else if (cmd.report) begin
      out_data_r   <= '0;
      out_status_r <= cmd.rep_status;
    end else if (load_mat) begin
      out_data_r   <= '0;
      out_status_r <= mat_bad ? ST_RANGE : ST_OK;
    end else if (load_vec) begin
      out_data_r   <= '0;
      out_status_r <= vec_bad ? ST_RANGE : ST_OK;
    end else begin
      out_data_r   <= '0;
      out_status_r <= ST_OK;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_status   = out_status_r;

  assign st.shape_ok   = shape_ok;
  assign st.count      = count;
  assign st.span_over  = span_over_r;
  assign st.sweep_last = last_c && last_r && last_j && last_s;
  assign st.pipe_empty = !(v1_r || v2_r || v3_r || wr_v_r);

endmodule

### src/kmvp_ctrl.sv
// ---------------------------------------------------------------------------
// kmvp_ctrl
// request decode, size check sequence and pass sequencing
// ---------------------------------------------------------------------------
`include "kronecker_matrix_vector_product_top_assert.svh"

module kmvp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      in_kind,
  output logic            busy,
  input  kmvp_pkg::stat_t st,
  output kmvp_pkg::cmd_t  cmd
);
  import kmvp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_SPAN  = 7'b0000100,
    S_CHK   = 7'b0001000,
    S_LEFT  = 7'b0010000,
    S_RUN   = 7'b0100000,
    S_DRAIN = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [SEL_W-1:0] k_r, k_nxt;
  logic [SEL_W-1:0] p_r, p_nxt;
  logic             src_b_r, src_b_nxt;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    p_nxt     = p_r;
    src_b_nxt = src_b_r;
    cmd       = '0;
    cmd.idx   = k_r;
    cmd.p     = p_r;
    cmd.src_b = src_b_r;
    case (state_r)
      S_IDLE: begin
        cmd.accept = start;
        if (start) begin
          case (kind_t'(in_kind))
            K_READ: begin
              state_nxt = S_READ;
            end
            K_START: begin
              if (!st.shape_ok) begin
                cmd.report     = 1'b1;
                cmd.rep_status = ST_SIZE;
              end else begin
                cmd.span_clr = 1'b1;
                k_nxt        = '0;
                state_nxt    = S_SPAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        cmd.rd_resp = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_SPAN: begin
        cmd.span_mul = 1'b1;
        if (CNT_W'(k_r) == st.count - CNT_W'(1)) begin
          state_nxt = S_CHK;
        end else begin
          k_nxt = k_r + SEL_W'(1);
        end
      end
      S_CHK: begin
        if (st.span_over) begin
          cmd.report     = 1'b1;
          cmd.rep_status = ST_SIZE;
          state_nxt      = S_IDLE;
        end else begin
          p_nxt         = SEL_W'(st.count - CNT_W'(1));
          cmd.right_clr = 1'b1;
          cmd.left_clr  = 1'b1;
          k_nxt         = '0;
          src_b_nxt     = 1'b0;
          state_nxt     = S_LEFT;
        end
      end
      S_LEFT: begin
        if (k_r == p_r) begin
          cmd.sweep_init = 1'b1;
          state_nxt      = S_RUN;
        end else begin
          cmd.left_mul = 1'b1;
          k_nxt        = k_r + SEL_W'(1);
        end
      end
      S_RUN: begin
        cmd.run = 1'b1;
        if (st.sweep_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.idx = p_r;
        if (st.pipe_empty) begin
          cmd.right_mul = 1'b1;
          src_b_nxt     = !src_b_r;
          if (p_r == '0) begin
            cmd.report     = 1'b1;
            cmd.rep_status = ST_OK;
            cmd.set_res    = 1'b1;
            cmd.res_b      = st.count[0];
            state_nxt      = S_IDLE;
          end else begin
            p_nxt        = p_r - SEL_W'(1);
            k_nxt        = '0;
            cmd.left_clr = 1'b1;
            state_nxt    = S_LEFT;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      p_r     <= '0;
      src_b_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      p_r     <= p_nxt;
      src_b_r <= src_b_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `KMVP_ASSERT_NEXT(a_run_exit, clk, rst_n, state_r == S_RUN, state_r == S_RUN || state_r == S_DRAIN)
  `KMVP_ASSERT_NEXT(a_drain_wait, clk, rst_n, state_r == S_DRAIN && !st.pipe_empty, state_r == S_DRAIN)
  `KMVP_ASSERT_SAME(a_idle_empty, clk, rst_n, !busy, st.pipe_empty)

endmodule

### src/kronecker_matrix_vector_product_top.sv
// ---------------------------------------------------------------------------
// kronecker_matrix_vector_product_top
// y = (a0 x a1 x a2 x a3) x with q16.16 factors loaded element by element
// ---------------------------------------------------------------------------
// channel  handshake           payload
// in       start & !busy       in_kind, in_factor_sel, in_row_idx, in_col_idx,
//                              in_vec_idx, in_data_in
// out      out_valid (1 cycle) out_data_out, out_status
// cfg      cfg_we              cfg_index, cfg_data
//
// loads answer in the cycle after the request and leave busy low
// a read holds busy for one cycle (S_READ), and its answer is registered there
// a start holds busy through the size check (S_SPAN per factor, S_CHK), then
//   per factor p setup, left*right*rows*cols macs (one buffer read each), drain
// its status appears as busy drops; a bad size answers like a load, and a span
// over MAX_VEC from S_CHK; rst_n is synchronous; the output has no back pressure
// ---------------------------------------------------------------------------
module kronecker_matrix_vector_product_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_kind,
  input  logic [kmvp_pkg::SEL_W-1:0]         in_factor_sel,
  input  logic [kmvp_pkg::DIM_W-1:0]         in_row_idx,
  input  logic [kmvp_pkg::DIM_W-1:0]         in_col_idx,
  input  logic [kmvp_pkg::VEC_AW-1:0]        in_vec_idx,
  input  logic signed [kmvp_pkg::DATA_W-1:0] in_data_in,
  output logic                               out_valid,
  output logic signed [kmvp_pkg::DATA_W-1:0] out_data_out,
  output logic [1:0]                         out_status,
  input  logic                               cfg_we,
  input  logic [kmvp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kmvp_pkg::SIZE_W-1:0]        cfg_data
);
  import kmvp_pkg::*;

  cmd_t  cmd;
  stat_t st;

  kmvp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .busy    (busy),
    .st      (st),
    .cmd     (cmd)
  );

  kmvp_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_kind       (in_kind),
    .in_factor_sel (in_factor_sel),
    .in_row_idx    (in_row_idx),
    .in_col_idx    (in_col_idx),
    .in_vec_idx    (in_vec_idx),
    .in_data_in    (in_data_in),
    .out_valid     (out_valid),
    .out_data_out  (out_data_out),
    .out_status    (out_status)
  );

endmodule

### verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// checks the kronecker matrix-vector product block against a predictor
// ---------------------------------------------------------------------------
// the predictor keeps its own factor store, both vector buffers and the size
// registers. Each phase sets a shape, loads every factor and vector entry
// the start needs, then mixes starts, reads and loads with random gaps.
// Bad shapes, a tall 8x1 chain filling the whole vector and saturating data
// are all covered. Every request gets exactly one response, checked in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import kmvp_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  typedef struct {
    logic [31:0] d;
    logic [1:0]  s;
  } answer_t;

  class kron_scoreboard;
    logic [3:0]  rows[4];
    logic [3:0]  cols[4];
    logic [31:0] fstore[FSTORE_DEPTH];
    bit          fs_ok[FSTORE_DEPTH];
    logic [31:0] vbuf[2][MAX_VEC];
    bit          vok[2][MAX_VEC];
    bit          res_b;
    answer_t     pending[$];
    int          errors;
    int          checked;

    function new();
      for (int k = 0; k < 4; k++) begin
        rows[k] = 0;
        cols[k] = 0;
      end
      rows[0] = 1;
      cols[0] = 1;
    endfunction

    function void write_reg(int idx, logic [3:0] v);
      if (idx[0]) cols[idx >> 1] = v;
      else rows[idx >> 1] = v;
    endfunction

    function int shape_count();
      bit absent;
      int span;
      int cnt;
      absent = 0;
      span = 1;
      cnt = 0;
      for (int k = 0; k < 4; k++) begin
        if (rows[k] == 0) begin
          if (k == 0) return -1;
          absent = 1;
          continue;
        end
        if (absent || cols[k] == 0 || rows[k] > MAX_DIM || cols[k] > MAX_DIM) return -1;
        span *= (rows[k] > cols[k]) ? rows[k] : cols[k];
        if (span > MAX_VEC) return -1;
        cnt = k + 1;
      end
      return cnt;
    endfunction

    function logic [31:0] round_sat(logic signed [67:0] acc);
      logic signed [67:0] t;
      t = (acc + 68'sd32768) >>> 16;
      if (t > 68'sd2147483647) return 32'h7fffffff;
      if (t < -68'sd2147483648) return 32'h80000000;
      return t[31:0];
    endfunction

    function void apply_factor(bit src, int p, int left, int right, int nr, int nc);
      logic signed [67:0] acc;
      logic signed [67:0] mm;
      logic signed [67:0] xx;
      for (int s = 0; s < left; s++)
        for (int j = 0; j < right; j++)
          for (int r = 0; r < nr; r++) begin
            acc = 0;
            for (int c = 0; c < nc; c++) begin
              mm = $signed(fstore[(p * MAX_DIM + r) * MAX_DIM + c]);
              xx = $signed(vbuf[src][(s * right * nc + c * right + j) % MAX_VEC]);
              acc += mm * xx;
            end
            vbuf[!src][(s * right * nr + r * right + j) % MAX_VEC] = round_sat(acc);
            vok[!src][(s * right * nr + r * right + j) % MAX_VEC] = 1;
          end
    endfunction

    function logic [1:0] run_chain();
      int cnt;
      int left;
      int right;
      bit src;
      cnt = shape_count();
      if (cnt < 0) return ST_SIZE;
      src = 0;
      for (int p = cnt - 1; p >= 0; p--) begin
        left = 1;
        right = 1;
        for (int i = 0; i < p; i++) left *= cols[i];
        for (int i = p + 1; i < cnt; i++) right *= rows[i];
        apply_factor(src, p, left, right, rows[p], cols[p]);
        src = !src;
      end
      res_b = cnt[0];
      return ST_OK;
    endfunction

    function void note(kind_t k, int sel, int row, int col, int vidx, logic [31:0] data);
      answer_t a;
      a.d = 0;
      a.s = ST_OK;
      case (k)
        K_LOAD_MAT: begin
          fstore[(sel * MAX_DIM + row) * MAX_DIM + col] = data;
          fs_ok[(sel * MAX_DIM + row) * MAX_DIM + col] = 1;
        end
        K_LOAD_VEC: begin
          vbuf[0][vidx] = data;
          vok[0][vidx] = 1;
        end
        K_START: a.s = run_chain();
        default: a.d = vbuf[res_b][vidx];
      endcase
      pending.insert(pending.size(), a);
    endfunction

    function void check(logic [31:0] d, logic [1:0] s);
      answer_t a;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: response with none outstanding, data_out %h status %0d", $time, d, s);
        errors++;
        return;
      end
      a = pending.pop_front();
      if (d !== a.d) begin
        $display("%0t: data_out expected %h actual %h", $time, a.d, d);
        errors++;
      end
      if (s !== a.s) begin
        $display("%0t: status expected %0d actual %0d", $time, a.s, s);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [1:0]               in_kind;
  logic [SEL_W-1:0]         in_factor_sel;
  logic [DIM_W-1:0]         in_row_idx;
  logic [DIM_W-1:0]         in_col_idx;
  logic [VEC_AW-1:0]        in_vec_idx;
  logic signed [DATA_W-1:0] in_data_in;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_data_out;
  logic [1:0]               out_status;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [SIZE_W-1:0]        cfg_data;

  kron_scoreboard sb;
  int  n_sent;
  int  n_starts;
  int  n_bad;
  int  n_reads;
  int  n_phases;
  int  idle_cnt;
  int  last_len;
  bit  no_gaps;

  kronecker_matrix_vector_product_top i_dut (.*);

  initial clk = 0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_data_out, out_status);
    if (!rst_n || out_valid || (start && !busy)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt == IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function logic [31:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom();
      default: return $urandom_range(0, 32'h7ffff) - 32'h40000;
    endcase
  endfunction

  task automatic send(kind_t k, int sel, int row, int col, int vidx, logic [31:0] data);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk) start = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1;
    in_kind = k;
    in_factor_sel = SEL_W'(sel);
    in_row_idx = DIM_W'(row);
    in_col_idx = DIM_W'(col);
    in_vec_idx = VEC_AW'(vidx);
    in_data_in = data;
    do @(posedge clk); while (busy);
    sb.note(k, sel, row, col, vidx, data);
    n_sent++;
    if (k == K_START) n_starts++;
    if (k == K_READ) n_reads++;
  endtask

  task automatic read_some(int n);
    int idx;
    repeat (n) begin
      for (int t = 0; t < 40; t++) begin
        idx = $urandom_range(0, last_len - 1);
        if (sb.vok[sb.res_b][idx]) begin
          send(K_READ, $urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 7),
               idx, $urandom());
          break;
        end
      end
    end
  endtask

  task automatic drain();
    @(negedge clk) start = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_shape(logic [3:0] r[4], logic [3:0] c[4]);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we = 1;
      cfg_index = CFG_IDX_W'(i);
      cfg_data = i[0] ? c[i >> 1] : r[i >> 1];
      sb.write_reg(i, cfg_data);
    end
    @(negedge clk) cfg_we = 0;
  endtask

  task automatic prepare_and_start(int cnt);
    int n;
    n = 1;
    for (int p = 0; p < cnt; p++) begin
      n *= sb.cols[p];
      for (int r = 0; r < sb.rows[p]; r++)
        for (int c = 0; c < sb.cols[p]; c++)
          if (!sb.fs_ok[(p * MAX_DIM + r) * MAX_DIM + c] || $urandom_range(0, 1))
            send(K_LOAD_MAT, p, r, c, $urandom_range(0, 4095), rand_val());
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) read_some(1);
      if (!sb.vok[0][i] || $urandom_range(0, 2) == 0)
        send(K_LOAD_VEC, $urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 7),
             i, rand_val());
    end
    send(K_START, $urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 7),
         $urandom_range(0, 4095), $urandom());
    last_len = 1;
    for (int p = 0; p < cnt; p++) last_len *= sb.rows[p];
  endtask

  initial begin
    logic [3:0] r[4];
    logic [3:0] c[4];
    int cnt;
    int pick;
    sb = new();
    n_sent = 0;
    n_starts = 0;
    n_bad = 0;
    n_reads = 0;
    n_phases = 0;
    idle_cnt = 0;
    last_len = 1;
    no_gaps = 0;
    rst_n = 0;
    start = 0;
    in_kind = 0;
    in_factor_sel = 0;
    in_row_idx = 0;
    in_col_idx = 0;
    in_vec_idx = 0;
    in_data_in = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    repeat (11) @(negedge clk);
    rst_n = 1;

    // reset shape is a single 1x1 factor
    send(K_LOAD_MAT, 0, 0, 0, 0, 32'h7fffffff);
    send(K_LOAD_VEC, 0, 0, 0, 0, 32'h7fffffff);
    send(K_READ, 0, 0, 0, 0, 0);
    send(K_START, 0, 0, 0, 0, 0);
    send(K_READ, 3, 7, 7, 0, 32'hffffffff);
    send(K_LOAD_VEC, 0, 0, 0, 0, 32'h80000000);
    send(K_START, 0, 0, 0, 0, 0);
    send(K_READ, 0, 0, 0, 0, 0);
    send(K_LOAD_MAT, 0, 0, 0, 4095, 32'h00010000);
    send(K_LOAD_MAT, 3, 7, 7, 4095, 32'h80000000);
    send(K_LOAD_VEC, 3, 7, 7, 4095, 32'h00008000);
    send(K_START, 3, 7, 7, 4095, 0);
    send(K_READ, 0, 0, 0, 0, 0);

    while (n_sent < 1850) begin
      drain();
      n_phases++;
      pick = $urandom_range(0, 19);
      for (int k = 0; k < 4; k++) begin
        r[k] = 0;
        c[k] = 4'($urandom_range(0, 15));
      end
      if (pick < 2) begin
        case ($urandom_range(0, 3))
          0: begin
            r[0] = 0;
            r[1] = 2;
            c[1] = 2;
          end
          1: begin
            r[0] = 2;
            c[0] = 2;
            r[2] = 3;
            c[2] = 1;
          end
          2: begin
            r[0] = 4'($urandom_range(9, 15));
            c[0] = 1;
          end
          default: begin
            r[0] = 3;
            r[1] = 2;
            c[1] = 0;
          end
        endcase
      end else if (pick == 2) begin
        for (int k = 0; k < 4; k++) begin
          r[k] = 8;
          c[k] = 1;
        end
      end else if (pick == 3) begin
        r[0] = 8;
        c[0] = 8;
      end else begin
        cnt = $urandom_range(1, 4);
        for (int k = 0; k < cnt; k++) begin
          r[k] = 4'($urandom_range(1, cnt <= 2 ? 8 : 4));
          c[k] = 4'($urandom_range(1, cnt <= 2 ? 8 : 3));
        end
      end
      write_shape(r, c);
      no_gaps = ($urandom_range(0, 3) == 0);
      cnt = sb.shape_count();
      if (cnt < 0) begin
        n_bad++;
        send(K_START, 0, 0, 0, 0, $urandom());
        read_some($urandom_range(1, 4));
      end else begin
        repeat ($urandom_range(0, 3) == 0 ? 2 : 1) begin
          prepare_and_start(cnt);
          read_some(pick == 2 ? 40 : $urandom_range(1, 12));
        end
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("%0d requests over %0d shape phases: %0d starts (%0d bad shape), %0d reads",
             n_sent, n_phases, n_starts, n_bad, n_reads);
    $display("%0d responses checked", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
